// ===== hdl/lma_pkg.sv =====
// Shared types and constants for the label moment accumulator.
// No dependencies; used by the top level, the divider and the checker.
package lma_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int LABEL_COUNT_DEF = 256;

  // Field and accumulator widths fixed by the interface.
  localparam int LAB_W   = 8;
  localparam int DIM_W   = 11;
  localparam int CNT_W   = 21;
  localparam int SUM1_W  = 30;
  localparam int SUM2_W  = 40;
  localparam int CEN_W   = 10;
  localparam int U11_W   = 41;
  localparam int U2_W    = 40;
  localparam int MOM_W   = 42;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [SUM1_W-1:0] sx;
    logic [SUM1_W-1:0] sy;
    logic [SUM2_W-1:0] sxy;
    logic [SUM2_W-1:0] sxx;
    logic [SUM2_W-1:0] syy;
    logic [CNT_W-1:0]  bnd;
  } acc_entry_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// ===== hdl/label_moment_accumulator.sv =====
// Per-label moment accumulator: top level with sequencer, row store and label table.
// Depends on lma_pkg, lma_ram and lma_div.
//
//  channel | direction | fields                                   | handshake
//  in      | input     | op, label                                | in_valid / in_stall
//  out     | output    | label_out .. perimeter                   | out_valid / out_stall
//  cfg     | APB       | image_width @0x0, image_height @0x4      | psel / penable / pready
//
// A pixel of the first row goes straight to the row store and table update; from the second row on
// the pixel above is settled first (row store reads, an optional boundary update, then
// a table read-modify-write); the last pixel of a frame then settles each column of the last row.
// A query runs the bit-serial centroid dividers, then the moment products; an empty label skips both.
// Reset and a clear op run a clearing pass over every entry of the label table;
// no transfer is taken in meanwhile. A query result waits in the output register under
// stall while the next item is taken.
module label_moment_accumulator #(
  parameter int MAX_WIDTH   = lma_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = lma_pkg::MAX_HEIGHT_DEF,
  parameter int LABEL_COUNT = lma_pkg::LABEL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [lma_pkg::LAB_W-1:0]    label,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lma_pkg::LAB_W-1:0]    label_out,
  output logic                         empty_res,
  output logic [lma_pkg::CNT_W-1:0]    area,
  output logic [lma_pkg::CEN_W-1:0]    center_x,
  output logic [lma_pkg::CEN_W-1:0]    center_y,
  output logic signed [lma_pkg::U11_W-1:0] moment_u11,
  output logic [lma_pkg::U2_W-1:0]     moment_u20,
  output logic [lma_pkg::U2_W-1:0]     moment_u02,
  output logic [lma_pkg::CNT_W-1:0]    perimeter,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lma_pkg::APB_AW-1:0]   paddr,
  input  logic [lma_pkg::APB_DW-1:0]   pwdata,
  output logic [lma_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int LW   = $clog2(LABEL_COUNT);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int EWW  = $clog2(MAX_WIDTH + 1);
  localparam int EHW  = $clog2(MAX_HEIGHT + 1);
  localparam int SAW  = $clog2(2 * MAX_WIDTH);
  localparam int SDEP = 2 * MAX_WIDTH;
  localparam int CMW  = (EWW > lma_pkg::DIM_W) ? ((EWW > EHW) ? EWW : EHW) :
                        ((EHW > lma_pkg::DIM_W) ? EHW : lma_pkg::DIM_W);
  localparam int AEW  = $bits(lma_pkg::acc_entry_t);
  localparam int MW   = lma_pkg::MOM_W;
  localparam int NW   = lma_pkg::CNT_W;
  localparam int S1W  = lma_pkg::SUM1_W;
  localparam int S2W  = lma_pkg::SUM2_W;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CLR  = 16'h0002,
    S_SRD1 = 16'h0004,
    S_SRD2 = 16'h0008,
    S_SCHK = 16'h0010,
    S_SWR  = 16'h0020,
    S_STW  = 16'h0040,
    S_ACC  = 16'h0080,
    S_POST = 16'h0100,
    S_FIN  = 16'h0200,
    S_QRD  = 16'h0400,
    S_QDIV = 16'h0800,
    S_QM1  = 16'h1000,
    S_QM2  = 16'h2000,
    S_QM3  = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t state;

  // configuration
  logic [lma_pkg::DIM_W-1:0] width_reg, height_reg;
  logic                      cfg_we;
  logic [CMW-1:0]            wr_ext, hr_ext;
  logic [EWW-1:0]            eff_w;
  logic [EHW-1:0]            eff_h;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == lma_pkg::REG_HEIGHT) ?
                  lma_pkg::APB_DW'(height_reg) : lma_pkg::APB_DW'(width_reg);
  assign wr_ext = CMW'(width_reg);
  assign hr_ext = CMW'(height_reg);

  always_comb begin
    if (wr_ext == '0)                 eff_w = EWW'(1);
    else if (wr_ext > CMW'(MAX_WIDTH)) eff_w = EWW'(MAX_WIDTH);
    else                              eff_w = EWW'(width_reg);
    if (hr_ext == '0)                  eff_h = EHW'(1);
    else if (hr_ext > CMW'(MAX_HEIGHT)) eff_h = EHW'(MAX_HEIGHT);
    else                               eff_h = EHW'(height_reg);
  end

  // frame position and working registers
  logic [XW-1:0]  col;
  logic [EHW-1:0] row;
  logic [LW-1:0]  clr_cnt;
  logic [XW-1:0]  s_x;
  logic           s_par, s_row0, s_final;
  logic [lma_pkg::LAB_W-1:0] s_below, s_me, s_left, p_lab, q_lab;

  logic in_frame, col_last, row_last, acc_ok, me_ok, bnd, q_empty;
  logic accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign in_frame = (EWW'(col) < eff_w) && (row < eff_h);
  assign col_last = (EWW'(col) + EWW'(1)) == eff_w;
  assign row_last = (row + EHW'(1)) == eff_h;
  assign acc_ok   = (p_lab != '0) && ({1'b0, p_lab} < 9'(LABEL_COUNT));
  assign me_ok    = (s_me != '0) && ({1'b0, s_me} < 9'(LABEL_COUNT));

  // row store
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_ra0, st_ra1;
  logic [lma_pkg::LAB_W-1:0] st_rd0, st_rd1;
  logic [XW-1:0]  x_dn, x_up;

  function automatic logic [SAW-1:0] saddr(input logic par, input logic [XW-1:0] xv);
    return par ? (SAW'(MAX_WIDTH) + SAW'(xv)) : SAW'(xv);
  endfunction

  assign x_dn = (s_x == '0) ? s_x : s_x - 1'b1;
  assign x_up = ((EWW'(s_x) + EWW'(1)) < EWW'(MAX_WIDTH)) ? XW'(s_x + 1'b1) : s_x;

  always_comb begin
    st_ra0 = saddr(s_par, s_x);
    st_ra1 = saddr(s_par, x_dn);
    if (state == S_SRD2) begin
      st_ra0 = saddr(s_par, x_up);
      st_ra1 = saddr(!s_par, s_x);
    end
  end

  assign st_we    = state == S_STW;
  assign st_waddr = saddr(row[0], col);

  lma_ram #(.WIDTH(lma_pkg::LAB_W), .DEPTH(SDEP)) u_store (
    .clk    (clk),
    .we     (st_we),
    .waddr  (st_waddr),
    .wdata  (p_lab),
    .raddr0 (st_ra0),
    .rdata0 (st_rd0),
    .raddr1 (st_ra1),
    .rdata1 (st_rd1)
  );

  // boundary test, evaluated in S_SCHK: right and up arrive then
  always_comb begin
    bnd = me_ok && (((s_x != '0) && (s_left != s_me)) ||
                    (((EWW'(s_x) + EWW'(1)) < eff_w) && (st_rd0 != s_me)) ||
                    (!s_row0 && (st_rd1 != s_me)) ||
                    (!s_final && (s_below != s_me)));
  end

  // label table
  lma_pkg::acc_entry_t tb_wdata, tb_rd0, tb_rd1, acc_next;
  logic           tb_we;
  logic [LW-1:0]  tb_waddr, tb_ra0, tb_ra1;
  logic [XW-1:0]  px;
  logic [YW-1:0]  py;
  logic [XW+YW-1:0] pxy;
  logic [2*XW-1:0]  pxx;
  logic [2*YW-1:0]  pyy;

  assign px  = col;
  assign py  = row[YW-1:0];
  assign pxy = (XW+YW)'(px) * (XW+YW)'(py);
  assign pxx = (2*XW)'(px) * (2*XW)'(px);
  assign pyy = (2*YW)'(py) * (2*YW)'(py);

  always_comb begin
    acc_next     = tb_rd0;
    acc_next.n   = tb_rd0.n + NW'(1);
    acc_next.sx  = tb_rd0.sx + S1W'(px);
    acc_next.sy  = tb_rd0.sy + S1W'(py);
    acc_next.sxy = tb_rd0.sxy + S2W'(pxy);
    acc_next.sxx = tb_rd0.sxx + S2W'(pxx);
    acc_next.syy = tb_rd0.syy + S2W'(pyy);
  end

  always_comb begin
    tb_we    = 1'b0;
    tb_waddr = p_lab[LW-1:0];
    tb_wdata = acc_next;
    case (state)
      S_CLR: begin
        tb_we    = 1'b1;
        tb_waddr = clr_cnt;
        tb_wdata = '0;
      end
      S_SWR: begin
        tb_we        = 1'b1;
        tb_waddr     = s_me[LW-1:0];
        tb_wdata     = tb_rd0;
        tb_wdata.bnd = tb_rd0.bnd + NW'(1);
      end
      S_ACC: begin
        tb_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign tb_ra0 = (state == S_SCHK) ? s_me[LW-1:0] : p_lab[LW-1:0];
  assign tb_ra1 = label[LW-1:0];

  lma_ram #(.WIDTH(AEW), .DEPTH(LABEL_COUNT)) u_table (
    .clk    (clk),
    .we     (tb_we),
    .waddr  (tb_waddr),
    .wdata  (tb_wdata),
    .raddr0 (tb_ra0),
    .rdata0 (tb_rd0),
    .raddr1 (tb_ra1),
    .rdata1 (tb_rd1)
  );

  // query datapath
  lma_pkg::div_ctl_t dcx, dcy;
  logic           div_start;
  logic [S1W-1:0] qx, qy;
  lma_pkg::acc_entry_t q_e;
  logic [XW-1:0]  cx;
  logic [YW-1:0]  cy;
  logic [MW-1:0]  p1, p2, p3, p4, q1, q2, q3;
  logic [NW+XW-1:0] p5;
  logic [NW+YW-1:0] p6;
  logic           r_empty;
  logic [NW-1:0]  r_area, r_per;
  logic [lma_pkg::CEN_W-1:0] r_cx, r_cy;
  logic [MW-1:0]  r_u11, r_u20, r_u02;
  logic           slot_free;

  assign q_empty   = (q_lab == '0) || ({1'b0, q_lab} >= 9'(LABEL_COUNT)) || (tb_rd1.n == '0);
  assign div_start = (state == S_QRD) && !q_empty;
  assign slot_free = !out_valid || !out_stall;

  lma_div #(.W(S1W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tb_rd1.sx),
    .divisor  (S1W'(tb_rd1.n)),
    .quotient (qx),
    .ctl      (dcx)
  );

  lma_div #(.W(S1W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tb_rd1.sy),
    .divisor  (S1W'(tb_rd1.n)),
    .quotient (qy),
    .ctl      (dcy)
  );

  assign cx = qx[XW-1:0];
  assign cy = qy[YW-1:0];

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      col        <= '0;
      row        <= '0;
      width_reg  <= lma_pkg::DIM_RESET;
      height_reg <= lma_pkg::DIM_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              lma_pkg::OP_PIXEL: begin
                if (in_frame) state <= (row != '0) ? S_SRD1 : S_STW;
              end
              lma_pkg::OP_QUERY: state <= S_QRD;
              lma_pkg::OP_CLEAR: begin
                state   <= S_CLR;
                clr_cnt <= '0;
                col     <= '0;
                row     <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LW'(LABEL_COUNT - 1)) state <= S_IDLE;
        end
        S_SRD1: state <= S_SRD2;
        S_SRD2: state <= S_SCHK;
        S_SCHK: state <= bnd ? S_SWR : (s_final ? S_FIN : S_STW);
        S_SWR:  state <= s_final ? S_FIN : S_STW;
        S_STW:  state <= acc_ok ? S_ACC : S_POST;
        S_ACC:  state <= S_POST;
        S_POST: begin
          if (col_last) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          state <= (col_last && row_last) ? S_SRD1 : S_IDLE;
        end
        S_FIN: state <= ((EWW'(s_x) + EWW'(1)) == eff_w) ? S_IDLE : S_SRD1;
        S_QRD: state <= q_empty ? S_OUT : S_QDIV;
        S_QDIV: if (!dcx.busy && !dcy.busy) state <= S_QM1;
        S_QM1: state <= S_QM2;
        S_QM2: state <= S_QM3;
        S_QM3: state <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        if (paddr[2] == lma_pkg::REG_HEIGHT) height_reg <= pwdata[lma_pkg::DIM_W-1:0];
        else                                 width_reg  <= pwdata[lma_pkg::DIM_W-1:0];
        col <= '0;
        row <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p_lab   <= label;
        q_lab   <= label;
        s_x     <= col;
        s_par   <= !row[0];
        s_row0  <= row == EHW'(1);
        s_below <= label;
        s_final <= 1'b0;
      end
      S_SRD2: begin
        s_me   <= st_rd0;
        s_left <= st_rd1;
      end
      S_POST: begin
        s_x     <= '0;
        s_par   <= row[0];
        s_row0  <= row == '0;
        s_final <= 1'b1;
      end
      S_FIN: s_x <= s_x + 1'b1;
      S_QRD: begin
        q_e     <= tb_rd1;
        r_empty <= q_empty;
        r_area  <= q_empty ? '0 : tb_rd1.n;
        r_per   <= q_empty ? '0 : tb_rd1.bnd;
        r_cx    <= '0;
        r_cy    <= '0;
        r_u11   <= '0;
        r_u20   <= '0;
        r_u02   <= '0;
      end
      S_QM1: begin
        r_cx <= qx[lma_pkg::CEN_W-1:0];
        r_cy <= qy[lma_pkg::CEN_W-1:0];
        p1   <= MW'(cx) * MW'(q_e.sy);
        p2   <= MW'(cy) * MW'(q_e.sx);
        p3   <= MW'(cx) * MW'(q_e.sx);
        p4   <= MW'(cy) * MW'(q_e.sy);
        p5   <= (NW+XW)'(q_e.n) * (NW+XW)'(cx);
        p6   <= (NW+YW)'(q_e.n) * (NW+YW)'(cy);
      end
      S_QM2: begin
        q1 <= MW'(MW'(p5) * MW'(cy));
        q2 <= MW'(MW'(p5) * MW'(cx));
        q3 <= MW'(MW'(p6) * MW'(cy));
      end
      S_QM3: begin
        r_u11 <= MW'(q_e.sxy) - p1 - p2 + q1;
        r_u20 <= MW'(q_e.sxx) - {p3[MW-2:0], 1'b0} + q2;
        r_u02 <= MW'(q_e.syy) - {p4[MW-2:0], 1'b0} + q3;
      end
      default: ;
    endcase
    if (state == S_OUT && slot_free) begin
      label_out  <= q_lab;
      empty_res  <= r_empty;
      area       <= r_area;
      center_x   <= r_cx;
      center_y   <= r_cy;
      moment_u11 <= r_u11[lma_pkg::U11_W-1:0];
      moment_u20 <= r_u20[lma_pkg::U2_W-1:0];
      moment_u02 <= r_u02[lma_pkg::U2_W-1:0];
      perimeter  <= r_per;
    end
  end

  logic unused_ctl;
  assign unused_ctl = dcx.start ^ dcy.start;

endmodule

// ===== hdl/lma_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module lma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hdl/lma_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses lma_pkg for the control struct.
module lma_div #(
  parameter int W = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output logic [W-1:0]      quotient,
  output lma_pkg::div_ctl_t ctl
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign ctl.start = start;
  assign ctl.busy  = cnt != '0;

endmodule

// ===== hdl/lma_check.sv =====
// Port-level checker for the label moment accumulator, bound to the top level.
// Depends on lma_pkg for field widths.
module lma_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [lma_pkg::LAB_W-1:0] label_out,
  input logic                      empty_res,
  input logic [lma_pkg::CNT_W-1:0] area,
  input logic [lma_pkg::CNT_W-1:0] perimeter
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(label_out) && $stable(area))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> area == '0 && perimeter == '0)
    else $error("empty result carries data");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_res |-> area != '0 && perimeter <= area && label_out != '0)
    else $error("inconsistent nonempty result");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind label_moment_accumulator lma_check u_check (.*);
